>>> rtl/rsec_pkg.sv
// Package for the rotational sector table: sizes, codes, entry layout and
// the command and status groups between the controller and the datapath.
// Depends on nothing; every other file but rsec_ram imports it.
`timescale 1ns / 1ps

package rsec_pkg;

  // Table geometry.
  localparam int MAX_SECTORS    = 32;
  localparam int POSITION_WIDTH = 18;
  localparam int ID_W           = 8;
  localparam int IDX_W          = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
  localparam int CNT_W          = $clog2(MAX_SECTORS + 1);

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_FIND   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  // One stored sector.
  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic [POSITION_WIDTH-1:0] pos;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_RD,
    S_INS_CMP,
    S_FIND_RD,
    S_FIND_CMP,
    S_FIND_END,
    S_READ_WAIT,
    S_RESP
  } state_t;

  // Table read address selection.
  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX_M1,
    RD_IDX_M2,
    RD_SLOT
  } rd_sel_t;

  // What the staged result is loaded from.
  typedef enum logic [2:0] {
    RES_NONE,
    RES_CLEAR,
    RES_FULL,
    RES_NOT_FOUND,
    RES_RANGE,
    RES_INSERT,
    RES_FIND,
    RES_READ
  } res_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     clear_cnt;
    logic     count_inc;
    logic     ins_start;
    logic     find_start;
    logic     find_eval;
    logic     idx_inc;
    logic     idx_dec;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_shift;
    logic     wr_new;
    res_sel_t res_sel;
    logic     load_rsp;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic count_zero;
    logic full;
    logic slot_ok;
    logic idx_zero;
    logic idx_one;
    logic shift_needed;
    logic find_stop;
    logic rsp_free;
  } stat_t;

endpackage

>>> rtl/rsec_req_if.sv
// Request channel of the rotational sector table: valid, ready and one
// operation with its operands. Depends on rsec_pkg.
`timescale 1ns / 1ps

interface rsec_req_if import rsec_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                op;
  logic [ID_W-1:0]           sector_id;
  logic [POSITION_WIDTH-1:0] sector_position;
  logic [POSITION_WIDTH-1:0] time_now;
  logic [IDX_W-1:0]          slot_index;

  modport source (output valid, op, sector_id, sector_position, time_now, slot_index,
                  input ready);
  modport sink   (input valid, op, sector_id, sector_position, time_now, slot_index,
                  output ready);
endinterface

>>> rtl/rsec_rsp_if.sv
// Response channel of the rotational sector table: valid, ready and one
// result item. Depends on rsec_pkg.
`timescale 1ns / 1ps

interface rsec_rsp_if import rsec_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [IDX_W-1:0]          hit_slot;
  logic [ID_W-1:0]           hit_id;
  logic [POSITION_WIDTH-1:0] hit_position;
  logic [CNT_W-1:0]          entry_count;

  modport source (output valid, status, hit_slot, hit_id, hit_position, entry_count,
                  input ready);
  modport sink   (input valid, status, hit_slot, hit_id, hit_position, entry_count,
                  output ready);
endinterface

>>> rtl/rotational_sector_table.sv
// Top level of the rotational sector table: request and response channels,
// controller and datapath. Depends on rsec_pkg, rsec_req_if, rsec_rsp_if,
// rsec_ctrl and rsec_dp.
`timescale 1ns / 1ps

// Holds one track's sectors in a 32-entry RAM, kept sorted by rotational
// position, and serves one request at a time. A request is taken only while
// the block is idle, but the next one is taken while the previous result
// still waits in the output register. Clear, insert into a full table, find
// on an empty table and an out-of-range read are settled at decode; a read
// waits for the registered RAM read; an insert into a non-empty table first
// moves every held entry positioned after the new one up one slot; a find
// scans the entries in position order, stopping at the first match at or
// past the given time, at most the number held. The longest operation is a
// find over a full table. A result that cannot enter the output register
// because the previous one still waits there holds the controller until it
// drains. The single read port of the sector RAM delivers one entry per
// cycle to the insert shift and the find scan. The table needs no clearing
// pass after reset.
module rotational_sector_table import rsec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rsec_req_if.sink   req,
  rsec_rsp_if.source rsp
);

  cmd_t  cmd;
  stat_t stat;

  rsec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rsec_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (req.op),
    .in_id      (req.sector_id),
    .in_pos     (req.sector_position),
    .in_now     (req.time_now),
    .in_slot    (req.slot_index),
    .rsp_ready  (rsp.ready),
    .rsp_valid  (rsp.valid),
    .rsp_status (rsp.status),
    .rsp_slot   (rsp.hit_slot),
    .rsp_id     (rsp.hit_id),
    .rsp_pos    (rsp.hit_position),
    .rsp_count  (rsp.entry_count)
  );

endmodule

>>> rtl/rsec_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module rsec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/rsec_ctrl.sv
// Controller of the rotational sector table: sequences clear, insert,
// find and read over the datapath. Depends on rsec_pkg.
`timescale 1ns / 1ps

module rsec_ctrl import rsec_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_IDX;
    cmd.res_sel = RES_NONE;
    req_ready  = 1'b0;

    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end

      S_DECODE: begin
        unique case (stat.op)
          OP_CLEAR: begin
            cmd.clear_cnt = 1'b1;
            cmd.res_sel   = RES_CLEAR;
            state_next    = S_RESP;
          end
          OP_INSERT: begin
            if (stat.full) begin
              cmd.res_sel = RES_FULL;
              state_next  = S_RESP;
            end else begin
              cmd.ins_start = 1'b1;
              state_next    = S_INS_RD;
            end
          end
          OP_FIND: begin
            if (stat.count_zero) begin
              cmd.res_sel = RES_NOT_FOUND;
              state_next  = S_RESP;
            end else begin
              cmd.find_start = 1'b1;
              state_next     = S_FIND_RD;
            end
          end
          OP_READ: begin
            if (!stat.slot_ok) begin
              cmd.res_sel = RES_RANGE;
              state_next  = S_RESP;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_SLOT;
              state_next = S_READ_WAIT;
            end
          end
          default: state_next = S_RESP;
        endcase
      end

      // Fetch the entry just below the hole, or place at the bottom.
      S_INS_RD: begin
        if (stat.idx_zero) begin
          cmd.wr_new    = 1'b1;
          cmd.count_inc = 1'b1;
          cmd.res_sel   = RES_INSERT;
          state_next    = S_RESP;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_M1;
          state_next = S_INS_CMP;
        end
      end

      // Move a later entry up one slot and prefetch the next, or place here.
      S_INS_CMP: begin
        if (stat.shift_needed) begin
          cmd.wr_shift = 1'b1;
          cmd.idx_dec  = 1'b1;
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_IDX_M2;
          state_next   = stat.idx_one ? S_INS_RD : S_INS_CMP;
        end else begin
          cmd.wr_new    = 1'b1;
          cmd.count_inc = 1'b1;
          cmd.res_sel   = RES_INSERT;
          state_next    = S_RESP;
        end
      end

      S_FIND_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_IDX;
        cmd.idx_inc = 1'b1;
        state_next  = S_FIND_CMP;
      end

      // Streamed scan: judge one entry while the next one is read.
      S_FIND_CMP: begin
        cmd.find_eval = 1'b1;
        if (stat.find_stop) begin
          state_next = S_FIND_END;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_IDX;
          cmd.idx_inc = 1'b1;
        end
      end

      S_FIND_END: begin
        cmd.res_sel = RES_FIND;
        state_next  = S_RESP;
      end

      S_READ_WAIT: begin
        cmd.res_sel = RES_READ;
        state_next  = S_RESP;
      end

      // Hand the result to the output register once it is free.
      S_RESP: begin
        if (stat.rsp_free) begin
          cmd.load_rsp = 1'b1;
          state_next   = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/rsec_dp.sv
// Datapath of the rotational sector table: request registers, entry count,
// scan index, sector RAM, find bookkeeping and the output register.
// Depends on rsec_pkg and rsec_ram.
`timescale 1ns / 1ps

module rsec_dp import rsec_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output stat_t                     stat,
  input  logic [1:0]                in_op,
  input  logic [ID_W-1:0]           in_id,
  input  logic [POSITION_WIDTH-1:0] in_pos,
  input  logic [POSITION_WIDTH-1:0] in_now,
  input  logic [IDX_W-1:0]          in_slot,
  input  logic                      rsp_ready,
  output logic                      rsp_valid,
  output logic [1:0]                rsp_status,
  output logic [IDX_W-1:0]          rsp_slot,
  output logic [ID_W-1:0]           rsp_id,
  output logic [POSITION_WIDTH-1:0] rsp_pos,
  output logic [CNT_W-1:0]          rsp_count
);

  // Captured request.
  op_t                       req_op;
  logic [ID_W-1:0]           req_id;
  logic [POSITION_WIDTH-1:0] req_pos;
  logic [POSITION_WIDTH-1:0] req_now;
  logic [IDX_W-1:0]          req_slot;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_m1;
  logic [CNT_W-1:0] idx_m2;

  // Sector RAM ports.
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  entry_t           rd_data;
  logic             wr_en;

  // Find bookkeeping: first match anywhere and first match at or past time.
  logic                      any_hit;
  logic [IDX_W-1:0]          any_slot;
  logic [POSITION_WIDTH-1:0] any_pos;
  logic                      aft_hit;
  logic [IDX_W-1:0]          aft_slot;
  logic [POSITION_WIDTH-1:0] aft_pos;
  logic                      id_match;
  logic                      at_or_after;

  // Staged result.
  status_t                   res_status;
  logic [IDX_W-1:0]          res_slot;
  logic [ID_W-1:0]           res_id;
  logic [POSITION_WIDTH-1:0] res_pos;

  assign idx_m1 = idx - CNT_W'(1);
  assign idx_m2 = idx - CNT_W'(2);

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op   <= op_t'(in_op);
      req_id   <= in_id;
      req_pos  <= in_pos;
      req_now  <= in_now;
      req_slot <= in_slot;
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_cnt) begin
      count <= '0;
    end else if (cmd.count_inc) begin
      count <= count + CNT_W'(1);
    end
  end

  // Scan index.
  always_ff @(posedge clk) begin
    if (cmd.ins_start) begin
      idx <= count;
    end else if (cmd.find_start) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + CNT_W'(1);
    end else if (cmd.idx_dec) begin
      idx <= idx_m1;
    end
  end

  // RAM address and data selection.
  always_comb begin
    case (cmd.rd_sel)
      RD_IDX:    rd_addr = idx[IDX_W-1:0];
      RD_IDX_M1: rd_addr = idx_m1[IDX_W-1:0];
      RD_IDX_M2: rd_addr = idx_m2[IDX_W-1:0];
      default:   rd_addr = req_slot;
    endcase
  end

  assign wr_en   = cmd.wr_shift | cmd.wr_new;
  assign wr_addr = idx[IDX_W-1:0];
  assign wr_data = cmd.wr_shift ? rd_data : entry_t'{id: req_id, pos: req_pos};

  rsec_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SECTORS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Find comparisons on the entry just read, which sits at idx - 1.
  assign id_match    = (rd_data.id == req_id);
  assign at_or_after = (rd_data.pos >= req_now);

  always_ff @(posedge clk) begin
    if (rst || cmd.find_start) begin
      any_hit <= 1'b0;
      aft_hit <= 1'b0;
    end else if (cmd.find_eval && id_match) begin
      if (!any_hit) begin
        any_hit <= 1'b1;
      end
      if (at_or_after && !aft_hit) begin
        aft_hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.find_eval && id_match) begin
      if (!any_hit) begin
        any_slot <= idx_m1[IDX_W-1:0];
        any_pos  <= rd_data.pos;
      end
      if (at_or_after && !aft_hit) begin
        aft_slot <= idx_m1[IDX_W-1:0];
        aft_pos  <= rd_data.pos;
      end
    end
  end

  // Result staging.
  always_ff @(posedge clk) begin
    case (cmd.res_sel)
      RES_CLEAR: begin
        res_status <= ST_OK;
        res_slot   <= '0;
        res_id     <= '0;
        res_pos    <= '0;
      end
      RES_FULL, RES_NOT_FOUND, RES_RANGE: begin
        res_status <= (cmd.res_sel == RES_FULL)      ? ST_FULL :
                      (cmd.res_sel == RES_NOT_FOUND) ? ST_NOT_FOUND : ST_RANGE;
        res_slot   <= '0;
        res_id     <= '0;
        res_pos    <= '0;
      end
      RES_INSERT: begin
        res_status <= ST_OK;
        res_slot   <= idx[IDX_W-1:0];
        res_id     <= req_id;
        res_pos    <= req_pos;
      end
      RES_FIND: begin
        if (aft_hit) begin
          res_status <= ST_OK;
          res_slot   <= aft_slot;
          res_id     <= req_id;
          res_pos    <= aft_pos;
        end else if (any_hit) begin
          res_status <= ST_OK;
          res_slot   <= any_slot;
          res_id     <= req_id;
          res_pos    <= any_pos;
        end else begin
          res_status <= ST_NOT_FOUND;
          res_slot   <= '0;
          res_id     <= '0;
          res_pos    <= '0;
        end
      end
      RES_READ: begin
        res_status <= ST_OK;
        res_slot   <= req_slot;
        res_id     <= rd_data.id;
        res_pos    <= rd_data.pos;
      end
      default: ;
    endcase
  end

  // Output register; the count is taken after the operation has updated it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rsp) begin
      rsp_status <= res_status;
      rsp_slot   <= res_slot;
      rsp_id     <= res_id;
      rsp_pos    <= res_pos;
      rsp_count  <= count;
    end
  end

  // Status to the controller.
  always_comb begin
    stat.op           = req_op;
    stat.count_zero   = (count == '0);
    stat.full         = (count >= CNT_W'(MAX_SECTORS));
    stat.slot_ok      = (CNT_W'(req_slot) < count);
    stat.idx_zero     = (idx == '0);
    stat.idx_one      = (idx == CNT_W'(1));
    stat.shift_needed = (rd_data.pos > req_pos);
    stat.find_stop    = (id_match && at_or_after) || (idx == count);
    stat.rsp_free     = !rsp_valid || rsp_ready;
  end

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the rotational sector table: directed and random
// clear, insert, find and read transfers checked against a predictor of the track.
// Depends on rsec_pkg, rsec_req_if, rsec_rsp_if and rotational_sector_table.
`timescale 1ns / 1ps

module tb;
  import rsec_pkg::*;

  // One expected result, laid out like the response channel.
  typedef struct packed {
    status_t                   status;
    logic [IDX_W-1:0]          slot;
    logic [ID_W-1:0]           id;
    logic [POSITION_WIDTH-1:0] pos;
    logic [CNT_W-1:0]          count;
  } sector_result_t;

  localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

  logic clk;
  logic rst;

  rsec_req_if req ();
  rsec_rsp_if rsp ();

  rotational_sector_table dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Predicted track contents, kept sorted by position.
  logic [ID_W-1:0]           trk_ids [MAX_SECTORS];
  logic [POSITION_WIDTH-1:0] trk_pos [MAX_SECTORS];
  int                        trk_count;

  sector_result_t pending_results[$];
  int             errors;
  int             send_idle_pct;
  int             stall_pct;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #5_000_000;
    $display("[rotational_sector_table] ERROR");
    $finish;
  end

  // Receiver: stall at random, changing ready on the falling edge.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Apply one operation to the predicted track and return its result.
  function automatic sector_result_t apply_table_op(
    input op_t                       op,
    input logic [ID_W-1:0]           id,
    input logic [POSITION_WIDTH-1:0] pos,
    input logic [POSITION_WIDTH-1:0] now,
    input logic [IDX_W-1:0]          slot
  );
    sector_result_t r;
    int             at;
    int             start;
    int             idx;
    int             k;
    bit             hit;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_CLEAR: begin
        trk_count = 0;
      end
      OP_INSERT: begin
        if (trk_count >= MAX_SECTORS) begin
          r.status = ST_FULL;
        end else begin
          at = 0;
          while (at < trk_count && trk_pos[at] <= pos) at++;
          for (k = trk_count; k > at; k--) begin
            trk_ids[k] = trk_ids[k-1];
            trk_pos[k] = trk_pos[k-1];
          end
          trk_ids[at] = id;
          trk_pos[at] = pos;
          trk_count++;
          r.slot = IDX_W'(at);
          r.id   = id;
          r.pos  = pos;
        end
      end
      OP_FIND: begin
        hit = 1'b0;
        if (trk_count > 0) begin
          start = 0;
          while (start < trk_count && trk_pos[start] < now) start++;
          if (start >= trk_count) start = 0;
          for (k = 0; k < trk_count && !hit; k++) begin
            idx = (start + k) % trk_count;
            if (trk_ids[idx] == id) begin
              hit   = 1'b1;
              r.slot = IDX_W'(idx);
              r.id   = trk_ids[idx];
              r.pos  = trk_pos[idx];
            end
          end
        end
        if (!hit) r.status = ST_NOT_FOUND;
      end
      default: begin
        if (slot >= trk_count) begin
          r.status = ST_RANGE;
        end else begin
          r.slot = slot;
          r.id   = trk_ids[slot];
          r.pos  = trk_pos[slot];
        end
      end
    endcase
    r.count = CNT_W'(trk_count);
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    sector_result_t exp_r;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, status %0d slot %0d id %0d pos %0d cnt %0d",
                 $time, rsp.status, rsp.hit_slot, rsp.hit_id, rsp.hit_position,
                 rsp.entry_count);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", exp_r.status, rsp.status);
        check_field("hit_slot", exp_r.slot, rsp.hit_slot);
        check_field("hit_id", exp_r.id, rsp.hit_id);
        check_field("hit_position", exp_r.pos, rsp.hit_position);
        check_field("entry_count", exp_r.count, rsp.entry_count);
      end
    end
  end

  // Send one request; starts and ends on a falling edge, leaving valid high.
  task automatic send_op(
    input op_t                       op,
    input logic [ID_W-1:0]           id,
    input logic [POSITION_WIDTH-1:0] pos,
    input logic [POSITION_WIDTH-1:0] now,
    input logic [IDX_W-1:0]          slot
  );
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid           <= 1'b1;
    req.op              <= op;
    req.sector_id       <= id;
    req.sector_position <= pos;
    req.time_now        <= now;
    req.slot_index      <= slot;
    do @(posedge clk); while (!req.ready);
    pending_results.push_back(apply_table_op(op, id, pos, now, slot));
    @(negedge clk);
  endtask

  // Operand fields that an operation ignores carry random noise.
  task automatic do_clear();
    send_op(OP_CLEAR, ID_W'($urandom), POSITION_WIDTH'($urandom),
            POSITION_WIDTH'($urandom), IDX_W'($urandom));
  endtask

  task automatic do_insert(input logic [ID_W-1:0] id, input logic [POSITION_WIDTH-1:0] pos);
    send_op(OP_INSERT, id, pos, POSITION_WIDTH'($urandom), IDX_W'($urandom));
  endtask

  task automatic do_find(input logic [ID_W-1:0] id, input logic [POSITION_WIDTH-1:0] now);
    send_op(OP_FIND, id, POSITION_WIDTH'($urandom), now, IDX_W'($urandom));
  endtask

  task automatic do_read(input logic [IDX_W-1:0] slot);
    send_op(OP_READ, ID_W'($urandom), POSITION_WIDTH'($urandom),
            POSITION_WIDTH'($urandom), slot);
  endtask

  // Hold the sender off until every expected result has come back.
  task automatic wait_all_results();
    req.valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  // Positions on a coarse grid often collide, which exercises equal positions.
  function automatic logic [POSITION_WIDTH-1:0] rand_position();
    case ($urandom_range(5))
      0:       return POSITION_WIDTH'($urandom_range(7) * 32768);
      1:       return $urandom_range(1) ? POS_MAX - POSITION_WIDTH'($urandom_range(3))
                                        : POSITION_WIDTH'($urandom_range(3));
      default: return POSITION_WIDTH'($urandom);
    endcase
  endfunction

  // Extremes of every field, every operation and the special cases.
  task automatic test_basic_ops();
    do_clear();
    do_find(8'h00, 18'd0);
    do_read(5'd0);
    do_read(5'd31);
    do_insert(8'hFF, POS_MAX);
    do_insert(8'h00, 18'd0);
    do_insert(8'h5A, 18'd1000);
    do_insert(8'h33, 18'd1000);
    do_insert(8'h5A, 18'd200000);
    for (int s = 0; s < 5; s++) do_read(IDX_W'(s));
    do_find(8'h5A, 18'd0);
    do_find(8'h5A, 18'd1001);
    do_find(8'h5A, POS_MAX);
    do_find(8'h00, POS_MAX);
    do_find(8'hFF, POS_MAX);
    do_find(8'h77, 18'd5);
    do_read(5'd5);
    do_clear();
    do_read(5'd0);
  endtask

  // Fill the track with descending positions, then insert into a full track.
  task automatic test_full_table();
    do_clear();
    for (int i = 0; i < MAX_SECTORS; i++) begin
      do_insert(ID_W'(i), POS_MAX - POSITION_WIDTH'(i * 4096));
    end
    do_insert(8'hA5, 18'd77);
    do_read(5'd31);
    do_find(8'd0, POS_MAX);
    do_find(8'd31, 18'd0);
    do_clear();
  endtask

  // The sender pauses with results outstanding until the block is drained.
  task automatic test_drain_pause();
    send_idle_pct = 50;
    stall_pct     = 50;
    for (int i = 0; i < 4; i++) do_insert(ID_W'($urandom_range(3)), rand_position());
    wait_all_results();
    do_find(ID_W'($urandom_range(3)), POSITION_WIDTH'($urandom));
    wait_all_results();
    do_read(IDX_W'($urandom_range(4)));
    do_read(5'd31);
    wait_all_results();
  endtask

  // Random tracks: mostly a clear, a run of inserts and then queries against
  // what is held, so that finds hit and reads land inside the track.
  task automatic test_random_tracks(input int n_items, input int idle_pct,
                                    input int stall);
    int sent;
    int fill;
    int queries;
    int id_max;
    int pick;
    logic [POSITION_WIDTH-1:0] now;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 85) begin
        do_clear();
        sent++;
      end
      id_max = $urandom_range(1) ? 7 : 255;
      fill   = $urandom_range(34, 1);
      for (int i = 0; i < fill; i++) do_insert(ID_W'($urandom_range(id_max)), rand_position());
      sent += fill;
      queries = $urandom_range(25, 5);
      for (int q = 0; q < queries; q++) begin
        pick = $urandom_range(99);
        if (pick < 40 && trk_count > 0) begin
          // Time near a held position, or anywhere.
          case ($urandom_range(3))
            0:       now = POSITION_WIDTH'(trk_pos[$urandom_range(trk_count - 1)] +
                                           $urandom_range(2) - 1);
            1:       now = $urandom_range(1) ? POS_MAX : 18'd0;
            default: now = POSITION_WIDTH'($urandom);
          endcase
          do_find(trk_ids[$urandom_range(trk_count - 1)], now);
        end else if (pick < 55) begin
          do_find(ID_W'($urandom_range(id_max)), POSITION_WIDTH'($urandom));
        end else if (pick < 85) begin
          if (trk_count > 0 && $urandom_range(3) != 0) begin
            do_read(IDX_W'($urandom_range(trk_count - 1)));
          end else begin
            do_read(IDX_W'($urandom));
          end
        end else begin
          do_insert(ID_W'($urandom_range(id_max)), rand_position());
        end
      end
      sent += queries;
    end
    wait_all_results();
  endtask

  // Drain, let the longest operation finish, and report.
  task automatic finish_run();
    wait_all_results();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("[rotational_sector_table] OK");
    end else begin
      $display("[rotational_sector_table] ERROR");
    end
    $finish;
  endtask

  // Test sequence.
  initial begin
    rst                 = 1'b1;
    req.valid           = 1'b0;
    req.op              = OP_CLEAR;
    req.sector_id       = '0;
    req.sector_position = '0;
    req.time_now        = '0;
    req.slot_index      = '0;
    trk_count           = 0;
    errors              = 0;
    send_idle_pct       = 0;
    stall_pct           = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basic_ops();
    test_full_table();
    test_drain_pause();
    test_random_tracks(140, 0, 0);
    test_random_tracks(140, 86, 0);
    test_random_tracks(140, 0, 86);
    test_random_tracks(140, 21, 21);
    finish_run();
  end

endmodule

>>> sim.f
rtl/rsec_pkg.sv
rtl/rsec_req_if.sv
rtl/rsec_rsp_if.sv
rtl/rsec_ram.sv
rtl/rsec_ctrl.sv
rtl/rsec_dp.sv
rtl/rotational_sector_table.sv
tb/sv/tb.sv
